// ===== src/ptcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcs_pkg
// Shared types, widths and helpers for the polymerase track collision block.
// ----------------------------------------------------------------------------
package ptcs_pkg;

  // track geometry
  localparam int MAX_LEN        = 64;
  localparam int FIRST_LEN_DEF  = 64;
  localparam int SECOND_LEN_DEF = 64;
  localparam int LEN_W          = 7;   // holds 0..64
  localparam int GRP_W          = 8;   // popcount group size
  localparam int NGRP           = MAX_LEN / GRP_W;

  // item field widths
  localparam int DECAY_W = 8;
  localparam int DONE_W  = 16;
  localparam int OCC_W   = 7;
  localparam int CLR_W   = 8;

  // stream widths (byte padded)
  localparam int IN_W  = 152;
  localparam int OUT_W = 56;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLAP_LEN   = 1'b0,
    CFG_COLLISIONS_ON = 1'b1
  } cfg_reg_e;

  // per-cell control: clear before hand-off, clear after taking the neighbor bit
  typedef struct packed {
    logic pre_clr;
    logic post_clr;
  } cell_ctl_t;

  function automatic logic [3:0] pop8(input logic [GRP_W-1:0] v);
    logic [3:0] acc;
    acc = '0;
    for (int k = 0; k < GRP_W; k++) begin
      acc = acc + {3'b000, v[k]};
    end
    return acc;
  endfunction

endpackage

// ===== src/ptcs_cell.sv =====
// ----------------------------------------------------------------------------
// ptcs_cell
// One track position: holds an occupancy bit and passes it to its neighbor.
// ----------------------------------------------------------------------------
module ptcs_cell
  import ptcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,   // item accepted, shift this tick
  input  logic      nbr_i,   // bit handed over by the upstream neighbor
  input  cell_ctl_t ctl_i,
  output logic      hand_o,  // bit handed to the downstream neighbor
  output logic      bit_o
);

  logic bit_q, bit_d;

  assign bit_d  = nbr_i & ~ctl_i.post_clr;
  assign hand_o = bit_q & ~ctl_i.pre_clr;
  assign bit_o  = bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (adv_i) begin
      bit_q <= bit_d;
    end
  end

endmodule

// ===== src/ptcs_collide.sv =====
// ----------------------------------------------------------------------------
// ptcs_collide
// One collision pass: aligns the second track onto the first track's far end,
// finds positions busy on both and picks the side to clear by coin bit.
// ----------------------------------------------------------------------------
module ptcs_collide
  import ptcs_pkg::*;
#(
  parameter int FIRST_LEN  = FIRST_LEN_DEF,
  parameter int SECOND_LEN = SECOND_LEN_DEF
) (
  input  logic [FIRST_LEN-1:0]  f_vec_i,
  input  logic [SECOND_LEN-1:0] s_vec_i,
  input  logic [LEN_W-1:0]      base_i,   // first position of the overlap
  input  logic [MAX_LEN-1:0]    coins_i,
  input  logic                  en_i,
  output logic [FIRST_LEN-1:0]  clr_f_o,
  output logic [SECOND_LEN-1:0] clr_s_o,
  output logic [FIRST_LEN-1:0]  hit_o     // in first-track coordinates
);

  logic [FIRST_LEN-1:0] s_fit, s_al, c_al, s_hit_al, s_back;

  // second track resized to first-track width; bits past the overlap never matter
  for (genvar i = 0; i < FIRST_LEN; i++) begin : g_fit
    if (i < SECOND_LEN) begin : g_in
      assign s_fit[i] = s_vec_i[i];
    end else begin : g_out
      assign s_fit[i] = 1'b0;
    end
  end

  assign s_al     = s_fit << base_i;
  assign c_al     = coins_i[FIRST_LEN-1:0] << base_i;
  assign hit_o    = f_vec_i & s_al & {FIRST_LEN{en_i}};
  assign clr_f_o  = hit_o & ~c_al;
  assign s_hit_al = hit_o & c_al;
  assign s_back   = s_hit_al >> base_i;

  for (genvar j = 0; j < SECOND_LEN; j++) begin : g_back
    if (j < FIRST_LEN) begin : g_in
      assign clr_s_o[j] = s_back[j];
    end else begin : g_out
      assign clr_s_o[j] = 1'b0;
    end
  end

endmodule

// ===== src/polymerase_track_collision_step_unit.sv =====
// ----------------------------------------------------------------------------
// polymerase_track_collision_step_unit
// Two opposed occupancy tracks built as rows of shift cells, with two
// collision passes per tick and saturating transcript counters.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result side does not stall; both
//   tracks, both collision passes and the done counters update when the item is accepted.
// Pipeline: track update on acceptance, grouped popcount, final sum into the
//   output register.
// Reset: tracks and counters clear, overlap 0, collisions on, pipe empty.
// ----------------------------------------------------------------------------
module polymerase_track_collision_step_unit
  import ptcs_pkg::*;
#(
  parameter int FIRST_LEN  = FIRST_LEN_DEF,
  parameter int SECOND_LEN = SECOND_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] first_start, [1] second_start, [9:2] first_decay, [17:10] second_decay,
  // [81:18] coins_after_first, [145:82] coins_after_second, rest zero
  input  logic [IN_W-1:0]       s_axis_tdata,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] first_transcripts, [31:16] second_transcripts,
  // [38:32] first_occupancy, [45:39] second_occupancy,
  // [46] second_head_busy, [54:47] collisions_resolved, [55] zero
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int OV_MAX = (FIRST_LEN < SECOND_LEN) ? FIRST_LEN : SECOND_LEN;
  localparam logic [LEN_W-1:0] FLEN_L   = LEN_W'(FIRST_LEN);
  localparam logic [LEN_W-1:0] OV_MAX_L = LEN_W'(OV_MAX);
  localparam logic [DONE_W-1:0] DONE_MAX = '1;

  // --------------------------------------------------------------------------
  // Configuration: overlap kept as the first overlapped position of track one
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] base_q;
  logic             coll_on_q;
  logic [LEN_W-1:0] ov_eff;

  assign cfg_ready_o = 1'b1;
  assign ov_eff = (cfg_data_i > OV_MAX_L) ? OV_MAX_L : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= FLEN_L;   // zero overlap
      coll_on_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_OVERLAP_LEN:   base_q    <= FLEN_L - ov_eff;
        CFG_COLLISIONS_ON: coll_on_q <= cfg_data_i[0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input fields
  // --------------------------------------------------------------------------
  logic                fs, ss;
  logic [DECAY_W-1:0]  f_decay, s_decay;
  logic [MAX_LEN-1:0]  coins1, coins2;

  assign fs      = s_axis_tdata[0];
  assign ss      = s_axis_tdata[1];
  assign f_decay = s_axis_tdata[9:2];
  assign s_decay = s_axis_tdata[17:10];
  assign coins1  = s_axis_tdata[81:18];
  assign coins2  = s_axis_tdata[145:82];

  // --------------------------------------------------------------------------
  // Pipe handshake: accept -> p1 -> p2 -> output register
  // --------------------------------------------------------------------------
  logic p1_v_q, p2_v_q, out_v_q;
  logic accept, p1_go, out_ld;

  assign out_ld        = p2_v_q & (~out_v_q | m_axis_tready);
  assign p1_go         = p1_v_q & (~p2_v_q | out_ld);
  assign s_axis_tready = ~p1_v_q | p1_go;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      p1_v_q  <= accept | (p1_v_q & ~p1_go);
      p2_v_q  <= p1_go | (p2_v_q & ~out_ld);
      out_v_q <= out_ld | (out_v_q & ~m_axis_tready);
    end
  end

  // --------------------------------------------------------------------------
  // Track cells
  // --------------------------------------------------------------------------
  logic [FIRST_LEN-1:0]  f_bit, f_hand, f_sh, f_mid;
  logic [SECOND_LEN-1:0] s_bit, s_hand, s_sh;
  logic [FIRST_LEN-1:0]  clr_f1, clr_f2, hit1, hit2;
  logic [SECOND_LEN-1:0] clr_s1, clr_s2;
  cell_ctl_t             f_ctl [FIRST_LEN];
  cell_ctl_t             s_ctl [SECOND_LEN];

  // first track moves up: position 0 takes the start bit
  for (genvar i = 0; i < FIRST_LEN; i++) begin : g_first
    logic nbr;
    if (i == 0) begin : g_head
      assign nbr = fs;
    end else begin : g_body
      assign nbr = f_hand[i-1];
    end
    assign f_ctl[i].pre_clr  = 1'b0;
    assign f_ctl[i].post_clr = clr_f1[i] | clr_f2[i];
    ptcs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (accept),
      .nbr_i  (nbr),
      .ctl_i  (f_ctl[i]),
      .hand_o (f_hand[i]),
      .bit_o  (f_bit[i])
    );
  end

  // second track moves down: far position takes the start bit;
  // pass-one clears are applied before the bit moves on
  for (genvar j = 0; j < SECOND_LEN; j++) begin : g_second
    logic nbr;
    if (j == SECOND_LEN - 1) begin : g_head
      assign nbr = ss;
    end else begin : g_body
      assign nbr = s_hand[j+1];
    end
    assign s_ctl[j].pre_clr  = clr_s1[j];
    assign s_ctl[j].post_clr = clr_s2[j];
    ptcs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (accept),
      .nbr_i  (nbr),
      .ctl_i  (s_ctl[j]),
      .hand_o (s_hand[j]),
      .bit_o  (s_bit[j])
    );
  end

  assign f_sh  = {f_hand[FIRST_LEN-2:0], fs};
  assign s_sh  = {ss, s_hand[SECOND_LEN-1:1]};
  assign f_mid = f_sh & ~clr_f1;

  // pass one: shifted first track against the unshifted second track
  ptcs_collide #(
    .FIRST_LEN  (FIRST_LEN),
    .SECOND_LEN (SECOND_LEN)
  ) u_pass1 (
    .f_vec_i (f_sh),
    .s_vec_i (s_bit),
    .base_i  (base_q),
    .coins_i (coins1),
    .en_i    (coll_on_q),
    .clr_f_o (clr_f1),
    .clr_s_o (clr_s1),
    .hit_o   (hit1)
  );

  // pass two: after the second track has moved as well
  ptcs_collide #(
    .FIRST_LEN  (FIRST_LEN),
    .SECOND_LEN (SECOND_LEN)
  ) u_pass2 (
    .f_vec_i (f_mid),
    .s_vec_i (s_sh),
    .base_i  (base_q),
    .coins_i (coins2),
    .en_i    (coll_on_q),
    .clr_f_o (clr_f2),
    .clr_s_o (clr_s2),
    .hit_o   (hit2)
  );

  // --------------------------------------------------------------------------
  // Transcript counters: decay floors at zero, then the exiting bit saturates
  // --------------------------------------------------------------------------
  logic [DONE_W-1:0] f_done_q, s_done_q, f_done_d, s_done_d, f_sub, s_sub;
  logic              f_exit, s_exit;

  assign f_exit = f_bit[FIRST_LEN-1];
  assign s_exit = s_hand[0];

  always_comb begin
    f_sub = (f_done_q > DONE_W'(f_decay)) ? f_done_q - DONE_W'(f_decay) : '0;
    s_sub = (s_done_q > DONE_W'(s_decay)) ? s_done_q - DONE_W'(s_decay) : '0;
    f_done_d = (f_exit && f_sub != DONE_MAX) ? f_sub + 1'b1 : f_sub;
    s_done_d = (s_exit && s_sub != DONE_MAX) ? s_sub + 1'b1 : s_sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_done_q <= '0;
      s_done_q <= '0;
    end else if (accept) begin
      f_done_q <= f_done_d;
      s_done_q <= s_done_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage p1: counters and hit maps of the tick. The cells hold this tick's
  // tracks at least as long as p1 is occupied.
  // --------------------------------------------------------------------------
  logic [DONE_W-1:0]    p1_f_done_q, p1_s_done_q;
  logic [FIRST_LEN-1:0] p1_hit1_q, p1_hit2_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_f_done_q <= f_done_d;
      p1_s_done_q <= s_done_d;
      p1_hit1_q   <= hit1;
      p1_hit2_q   <= hit2;
    end
  end

  // pad to full width for the grouped popcount
  logic [MAX_LEN-1:0] f_pad, s_pad, h1_pad, h2_pad;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_pad
    if (k < FIRST_LEN) begin : g_f
      assign f_pad[k]  = f_bit[k];
      assign h1_pad[k] = p1_hit1_q[k];
      assign h2_pad[k] = p1_hit2_q[k];
    end else begin : g_fz
      assign f_pad[k]  = 1'b0;
      assign h1_pad[k] = 1'b0;
      assign h2_pad[k] = 1'b0;
    end
    if (k < SECOND_LEN) begin : g_s
      assign s_pad[k] = s_bit[k];
    end else begin : g_sz
      assign s_pad[k] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage p2: per-group popcounts
  // --------------------------------------------------------------------------
  logic [DONE_W-1:0] p2_f_done_q, p2_s_done_q;
  logic [3:0]        p2_f_grp_q [NGRP];
  logic [3:0]        p2_s_grp_q [NGRP];
  logic [4:0]        p2_c_grp_q [NGRP];
  logic              p2_head_q;

  always_ff @(posedge clk_i) begin
    if (p1_go) begin
      p2_f_done_q <= p1_f_done_q;
      p2_s_done_q <= p1_s_done_q;
      p2_head_q   <= s_bit[0];
      for (int g = 0; g < NGRP; g++) begin
        p2_f_grp_q[g] <= pop8(f_pad[g*GRP_W +: GRP_W]);
        p2_s_grp_q[g] <= pop8(s_pad[g*GRP_W +: GRP_W]);
        p2_c_grp_q[g] <= {1'b0, pop8(h1_pad[g*GRP_W +: GRP_W])}
                       + {1'b0, pop8(h2_pad[g*GRP_W +: GRP_W])};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: sum the groups
  // --------------------------------------------------------------------------
  logic [OCC_W-1:0] f_occ, s_occ;
  logic [CLR_W-1:0] clr_sum;

  always_comb begin
    f_occ   = '0;
    s_occ   = '0;
    clr_sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      f_occ   = f_occ + OCC_W'(p2_f_grp_q[g]);
      s_occ   = s_occ + OCC_W'(p2_s_grp_q[g]);
      clr_sum = clr_sum + CLR_W'(p2_c_grp_q[g]);
    end
  end

  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_data_q <= {1'b0, clr_sum, p2_head_q, s_occ, f_occ, p2_s_done_q, p2_f_done_q};
    end
  end

  assign m_axis_tdata = out_data_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polymerase track collision step unit. Ticks are
// queued by a stimulus sequence and fed through a clocked stream driver. A
// clocked monitor compares every result item with an in-bench copy of both
// tracks, their counts and the transcript counters.
// ----------------------------------------------------------------------------
module tb
  import ptcs_pkg::*;
();

  localparam int A_LEN     = FIRST_LEN_DEF;   // first track, shifts up
  localparam int B_LEN     = SECOND_LEN_DEF;  // second track, shifts down
  localparam int HOLD_CYC  = 300;             // long receiver stall
  localparam int TAIL_CYC  = 8;               // drain wait

  // input item, MSB first so the packed image matches the tdata layout
  typedef struct packed {
    logic [5:0]  pad;
    logic [63:0] coins_rev;   // pass two coin bits
    logic [63:0] coins_fwd;   // pass one coin bits
    logic [7:0]  decay_rev;
    logic [7:0]  decay_fwd;
    logic        start_rev;
    logic        start_fwd;
  } tick_t;

  // result item, MSB first
  typedef struct packed {
    logic        pad;
    logic [7:0]  cleared;
    logic        rev_head;
    logic [6:0]  occ_rev;
    logic [6:0]  occ_fwd;
    logic [15:0] done_rev;
    logic [15:0] done_fwd;
  } tally_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_OVERLAP_LEN;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  // bench control
  tick_t  tick_q[$];    // ticks waiting for the driver
  tally_t tally_q[$];   // predicted results, oldest first
  tick_t  tick_cur;     // item currently offered
  bit     steady   = 1'b0;  // no idling on either side
  bit     hold_req = 1'b0;
  bit     rx_hold  = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned n_res   = 0;

  // predicted block state, reset values
  logic [A_LEN-1:0] fwd_trk  = '0;
  logic [B_LEN-1:0] rev_trk  = '0;
  logic [6:0]       fwd_cnt  = '0;
  logic [6:0]       rev_cnt  = '0;
  logic [15:0]      fwd_done = '0;
  logic [15:0]      rev_done = '0;
  logic [6:0]       ovl_reg  = '0;
  logic             coll_on  = 1'b1;

  polymerase_track_collision_step_unit #(
    .FIRST_LEN (A_LEN),
    .SECOND_LEN(B_LEN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // one collision pass: index q pairs first-track slot A_LEN-ov+q with
  // second-track slot q; coin 0 drops the first-track polymerase
  function automatic int unsigned collide(input int unsigned ov, input logic [63:0] coins);
    int unsigned hits;
    int unsigned fp;
    hits = 0;
    for (int q = 0; q < ov; q++) begin
      fp = A_LEN - ov + q;
      if (fwd_trk[fp] && rev_trk[q]) begin
        if (!coins[q]) begin
          fwd_trk[fp] = 1'b0;
          fwd_cnt     = fwd_cnt - 7'd1;
        end else begin
          rev_trk[q] = 1'b0;
          rev_cnt    = rev_cnt - 7'd1;
        end
        hits++;
      end
    end
    return hits;
  endfunction

  task automatic step_tracks(input tick_t t);
    tally_t      r;
    int unsigned ov;
    int unsigned hits;
    logic        out_bit;
    // overlap clamps to the shorter track
    ov = ovl_reg;
    if (ov > A_LEN) ov = A_LEN;
    if (ov > B_LEN) ov = B_LEN;
    hits = 0;

    // decay first, floored at zero
    fwd_done = (fwd_done > 16'(t.decay_fwd)) ? fwd_done - 16'(t.decay_fwd) : 16'd0;
    rev_done = (rev_done > 16'(t.decay_rev)) ? rev_done - 16'(t.decay_rev) : 16'd0;

    // first track moves up, exits at the top slot
    out_bit = fwd_trk[A_LEN-1];
    fwd_trk = {fwd_trk[A_LEN-2:0], t.start_fwd};
    fwd_cnt = fwd_cnt + 7'(t.start_fwd) - 7'(out_bit);
    if (out_bit && fwd_done != 16'hFFFF) fwd_done = fwd_done + 16'd1;
    if (coll_on) hits += collide(ov, t.coins_fwd);

    // second track moves down, exits at slot zero
    out_bit = rev_trk[0];
    rev_trk = {t.start_rev, rev_trk[B_LEN-1:1]};
    rev_cnt = rev_cnt + 7'(t.start_rev) - 7'(out_bit);
    if (out_bit && rev_done != 16'hFFFF) rev_done = rev_done + 16'd1;
    if (coll_on) hits += collide(ov, t.coins_rev);

    r          = '0;
    r.done_fwd = fwd_done;
    r.done_rev = rev_done;
    r.occ_fwd  = fwd_cnt;
    r.occ_rev  = rev_cnt;
    r.rev_head = rev_trk[0];
    r.cleared  = 8'(hits);
    tally_q.insert(tally_q.size(), r);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_cnt++;
    if (err_cnt <= 60)
      $display("[%0t] result %0d: %s got %0d, want %0d", $time, n_res, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued ticks, predicts each accepted item
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) step_tracks(tick_cur);
      // tvalid gets at most one assignment per edge
      if (!s_axis_tvalid || fire) begin
        if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
          tick_cur = tick_q[0];
          tick_q.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tick_cur;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted result item against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tally_t got;
    tally_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (tally_q.size() == 0) begin
          report_mismatch("result item with nothing pending", got, 0);
        end else begin
          want = tally_q[0];
          tally_q.delete(0);
          if (got.done_fwd != want.done_fwd)
            report_mismatch("first_transcripts", got.done_fwd, want.done_fwd);
          if (got.done_rev != want.done_rev)
            report_mismatch("second_transcripts", got.done_rev, want.done_rev);
          if (got.occ_fwd != want.occ_fwd)
            report_mismatch("first_occupancy", got.occ_fwd, want.occ_fwd);
          if (got.occ_rev != want.occ_rev)
            report_mismatch("second_occupancy", got.occ_rev, want.occ_rev);
          if (got.rev_head != want.rev_head)
            report_mismatch("second_head_busy", got.rev_head, want.rev_head);
          if (got.cleared != want.cleared)
            report_mismatch("collisions_resolved", got.cleared, want.cleared);
        end
        n_res++;
      end
      m_axis_tready <= !rx_hold && (steady || $urandom_range(99) >= 36);
    end
  end

  // long receiver stall, counted here so the sender keeps pushing meanwhile
  initial begin : rx_stall
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // settles at a falling edge once nothing is queued, offered or outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || tally_q.size() != 0);
  endtask

  // register write; only called while the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OVERLAP_LEN:   ovl_reg = val;
      CFG_COLLISIONS_ON: coll_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic queue_tick(input logic fs, input logic ss, input logic [7:0] df,
                            input logic [7:0] dr, input logic [63:0] cf,
                            input logic [63:0] cr);
    tick_t t;
    t           = '0;
    t.start_fwd = fs;
    t.start_rev = ss;
    t.decay_fwd = df;
    t.decay_rev = dr;
    t.coins_fwd = cf;
    t.coins_rev = cr;
    tick_q.insert(tick_q.size(), t);
  endtask

  // mostly no decay so the counters climb, now and then a big bite
  function automatic logic [7:0] pick_decay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 8'd0;
    if (r < 93) return 8'($urandom_range(8, 1));
    return 8'($urandom_range(255));
  endfunction

  // solid coin words make one side always lose
  function automatic logic [63:0] pick_coins();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic tick_t rand_tick(input int unsigned pf, input int unsigned pr,
                                      input bit with_decay);
    tick_t t;
    t           = '0;
    t.start_fwd = ($urandom_range(99) < pf);
    t.start_rev = ($urandom_range(99) < pr);
    if (with_decay) begin
      t.decay_fwd = pick_decay();
      t.decay_rev = pick_decay();
    end
    t.coins_fwd = pick_coins();
    t.coins_rev = pick_coins();
    return t;
  endfunction

  // program both registers, run n ticks at the given start densities, drain
  task automatic run_phase(input logic [6:0] ovl, input logic on, input int unsigned pf,
                           input int unsigned pr, input int unsigned n,
                           input bit with_decay);
    write_reg(CFG_OVERLAP_LEN, ovl);
    write_reg(CFG_COLLISIONS_ON, {6'($urandom_range(63)), on});
    repeat (n) tick_q.insert(tick_q.size(), rand_tick(pf, pr, with_decay));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: full overlap, field extremes, decay past zero
    write_reg(CFG_OVERLAP_LEN, 7'd64);
    write_reg(CFG_COLLISIONS_ON, 7'd1);
    queue_tick(1'b1, 1'b1, 8'hFF, 8'hFF, '0, '1);
    queue_tick(1'b1, 1'b1, 8'h00, 8'h00, '1, '0);
    queue_tick(1'b0, 1'b1, 8'h01, 8'h80, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_tick(1'b1, 1'b0, 8'h80, 8'h01, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    for (int k = 0; k < 8; k++)
      queue_tick(1'b1, 1'b1, 8'h00, 8'h00, k[0] ? '1 : '0, k[1] ? '1 : '0);
    wait_idle();

    // overlap above track length must clamp
    write_reg(CFG_OVERLAP_LEN, 7'd127);
    for (int k = 0; k < 5; k++)
      queue_tick(k[0], 1'b1, 8'h00, 8'hFF, '1, '0);
    wait_idle();

    // zero overlap: no collision checks at all
    write_reg(CFG_OVERLAP_LEN, 7'd0);
    for (int k = 0; k < 5; k++)
      queue_tick(1'b1, k[0], 8'hFF, 8'h00, '0, '1);
    wait_idle();

    // random phases; every phase ends with the sender waiting for a full drain
    run_phase(7'd64, 1'b1, 50, 50, 130, 1'b1);
    hold_req = 1'b1;  // receiver stalls long, input side backs up
    run_phase(7'd127, 1'b1, 80, 80, 130, 1'b1);
    run_phase(7'd0, 1'b1, 60, 60, 100, 1'b1);
    run_phase(7'd1, 1'b1, 70, 40, 100, 1'b1);
    run_phase(7'd65, 1'b0, 60, 60, 100, 1'b1);
    steady = 1'b1;
    run_phase(7'($urandom_range(63, 2)), 1'b1, 90, 90, 130, 1'b1);
    steady = 1'b0;
    run_phase(7'd32, 1'b1, 95, 95, 120, 1'b1);
    run_phase(7'($urandom_range(127)), 1'($urandom_range(1)), 50, 80, 130, 1'b1);

    repeat (TAIL_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(64'd4_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
